>>> src/assert_macros.svh
// Assertion macros shared by the sender RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on clk, off while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a clock edge.
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> src/sssab_pkg.sv
// Shared constants and types of the strobe/ACK byte sender.
package sssab_pkg;

    localparam int US_PER_MS     = 1000;
    localparam int BITS_PER_BYTE = 8;

    localparam int SETUP_W       = 9;
    localparam int SETUP_MIN     = 5;
    localparam int SETUP_MAX     = 500;
    localparam int SETUP_RESET   = 50;
    localparam int TIMEOUT_W     = 16;
    localparam int TIMEOUT_RESET = 1500;
    localparam int BYTE_W        = 8;

    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = 8;

    // Watchdog limit in ticks and the counter that runs up to it.
    localparam longint unsigned LIMIT_MAX =
        ((64'd1 << TIMEOUT_W) - 64'd1) * longint'(US_PER_MS);
    localparam int LIMIT_W   = $clog2(LIMIT_MAX + 64'd1);
    localparam int BIT_CNT_W = $clog2(BITS_PER_BYTE + 1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SETUP_US    = 2'd0,
        REG_DRY_RUN     = 2'd1,
        REG_ACK_TIMEOUT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [SETUP_W-1:0] setup_us;
        logic               dry_run;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        logic              start_req;
        logic [BYTE_W-1:0] byte_value;
        logic              ack_level;
        logic              abort_req;
    } item_t;

    typedef struct packed {
        logic online_n;
        logic strobe_n;
        logic data_line;
        logic busy_res;
        logic done_res;
        logic success;
        logic timed_out;
    } result_t;

endpackage

>>> src/serial_strobe_ack_byte_sender.sv
// Top level of the strobe/ACK byte sender: channels, config port, result register.
//
// Each input item is one microsecond tick: start request with a byte, the
// sampled ACK level and an abort request. Each tick gives exactly one result
// item with the ONLINE/STROBE/DATA line levels after that tick plus busy,
// done, success and timeout status. The byte goes out LSB first, online mode
// with a strobe/ACK handshake per bit, dry-run mode with fixed strobe timing.
// The result of a tick is registered and is on m_axis in the cycle after the item
// is accepted. Throughput: one item per cycle while the receiver keeps up; the whole
// state step is a single combinational pass into the state and result registers.
// A result waiting in the output register does not block input while the
// receiver takes it in the same cycle; if the receiver stalls, s_axis_tready
// drops until the result is taken, and nothing is lost.
// Config writes (index 0 setup_us, 1 dry_run, 2 ack_wait_ms) are taken in
// any cycle and belong in idle time; setup_us is clamped to 5..500 on write.
// Reset: lines idle high, no transfer, setup_us 50, online mode, timeout
// 1500 ms, output register empty.
module serial_strobe_ack_byte_sender
    import sssab_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [0] start_req, [8:1] byte_value, [9] ack_level, [10] abort_req, rest zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] online_n, [1] strobe_n, [2] data_line, [3] busy_res, [4] done_res,
    // [5] success, [6] timed_out, [7] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

    cfg_t    cfg;
    item_t   item;
    result_t res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    step;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    assign item.start_req  = s_axis_tdata[0];
    assign item.byte_value = s_axis_tdata[BYTE_W:1];
    assign item.ack_level  = s_axis_tdata[BYTE_W+1];
    assign item.abort_req  = s_axis_tdata[BYTE_W+2];

    sssab_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_addr (cfg_addr),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    sssab_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0,
                            out_res_reg.timed_out,
                            out_res_reg.success,
                            out_res_reg.done_res,
                            out_res_reg.busy_res,
                            out_res_reg.data_line,
                            out_res_reg.strobe_n,
                            out_res_reg.online_n};

    `ASSERT_CLK(a_done_ends_busy, out_valid_reg && out_res_reg.done_res |-> !out_res_reg.busy_res, "transfer reported done while still busy")
    `ASSERT_CLK(a_idle_lines_high, out_valid_reg && !out_res_reg.busy_res |-> out_res_reg.online_n && out_res_reg.strobe_n && out_res_reg.data_line, "lines not idle high outside a transfer")
    `ASSERT_NEVER(a_success_without_done, out_valid_reg && out_res_reg.success && !out_res_reg.done_res, "success flagged without done")

endmodule

>>> src/sssab_cfg.sv
// Configuration registers: setup delay clamp, mode bit, watchdog limit in ticks.
module sssab_cfg
    import sssab_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_ADDR_W-1:0] wr_addr,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    logic [SETUP_W-1:0] setup_reg;
    logic [SETUP_W-1:0] setup_next;
    logic               dry_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;

    always_comb
    begin
        setup_next = wr_data[SETUP_W-1:0];
        if (setup_next < SETUP_W'(SETUP_MIN))
        begin
            setup_next = SETUP_W'(SETUP_MIN);
        end
        else if (setup_next > SETUP_W'(SETUP_MAX))
        begin
            setup_next = SETUP_W'(SETUP_MAX);
        end
        // ms to ticks once, at write time
        limit_next = LIMIT_W'(wr_data[TIMEOUT_W-1:0]) * LIMIT_W'(US_PER_MS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_reg <= SETUP_W'(SETUP_RESET);
            dry_reg   <= 1'b0;
            limit_reg <= LIMIT_W'(TIMEOUT_RESET * US_PER_MS);
        end
        else if (wr_en)
        begin
            case (wr_addr)
                REG_SETUP_US:    setup_reg <= setup_next;
                REG_DRY_RUN:     dry_reg   <= wr_data[0];
                REG_ACK_TIMEOUT: limit_reg <= limit_next;
                default:         ;
            endcase
        end
    end

    assign cfg.setup_us = setup_reg;
    assign cfg.dry_run  = dry_reg;
    assign cfg.limit    = limit_reg;

endmodule

>>> src/sssab_core.sv
// Transfer state machine: advances one step per accepted tick item.
module sssab_core
    import sssab_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SETUP   = 3'd1,
        PH_WAIT_HI = 3'd2,
        PH_WAIT_LO = 3'd3,
        PH_DRY1    = 3'd4,
        PH_DRY2    = 3'd5,
        PH_DRY3    = 3'd6
    } phase_t;

    typedef struct packed {
        logic online_n;
        logic strobe_n;
        logic data_line;
    } pins_t;

    localparam pins_t PINS_IDLE = '{online_n: 1'b1, strobe_n: 1'b1, data_line: 1'b1};

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [BYTE_W-1:0]    shift_reg;
    logic [BYTE_W-1:0]    shift_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_next;
    logic [SETUP_W-1:0]   delay_reg;
    logic [SETUP_W-1:0]   delay_next;
    logic [LIMIT_W-1:0]   wait_reg;
    logic [LIMIT_W-1:0]   wait_next;
    logic                 tflag_reg;
    logic                 tflag_next;
    pins_t                pins_reg;
    pins_t                pins_next;

    logic                 done;
    logic                 ok;
    logic [SETUP_W-1:0]   delay_inc;
    logic                 delay_over;
    logic [BIT_CNT_W-1:0] bit_inc;
    logic                 last_bit;
    logic                 ack_hit;

    always_comb
    begin
        phase_next   = phase_reg;
        shift_next   = shift_reg;
        bit_cnt_next = bit_cnt_reg;
        delay_next   = delay_reg;
        wait_next    = wait_reg;
        tflag_next   = tflag_reg;
        pins_next    = pins_reg;
        done         = 1'b0;
        ok           = 1'b0;

        // delay counter stops at setup_us; a lowered setup ends the delay now
        delay_inc  = (delay_reg < cfg.setup_us) ? delay_reg + 1'b1 : delay_reg;
        delay_over = (delay_inc >= cfg.setup_us);
        bit_inc    = bit_cnt_reg + 1'b1;
        last_bit   = (bit_inc >= BIT_CNT_W'(BITS_PER_BYTE));
        ack_hit    = (phase_reg == PH_WAIT_HI) ? item.ack_level : !item.ack_level;

        case (phase_reg)
            PH_IDLE:
            begin
                if (item.start_req)
                begin
                    tflag_next         = 1'b0;
                    shift_next         = item.byte_value;
                    bit_cnt_next       = '0;
                    pins_next.online_n = 1'b0;
                    if (cfg.dry_run)
                    begin
                        pins_next.data_line = item.byte_value[0];
                        delay_next          = '0;
                        phase_next          = PH_DRY1;
                    end
                    else if (item.abort_req)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        pins_next.data_line = item.byte_value[0];
                        delay_next          = '0;
                        phase_next          = PH_SETUP;
                    end
                end
            end
            PH_SETUP:
            begin
                delay_next = delay_inc;
                if (delay_over)
                begin
                    pins_next.strobe_n = 1'b0;
                    wait_next          = '0;
                    phase_next         = PH_WAIT_HI;
                end
            end
            PH_WAIT_HI, PH_WAIT_LO:
            begin
                if (ack_hit)
                begin
                    if (phase_reg == PH_WAIT_HI)
                    begin
                        pins_next.strobe_n = 1'b1;
                        wait_next          = '0;
                        phase_next         = PH_WAIT_LO;
                    end
                    else
                    begin
                        shift_next   = shift_reg >> 1;
                        bit_cnt_next = bit_inc;
                        if (last_bit)
                        begin
                            done = 1'b1;
                            ok   = 1'b1;
                        end
                        else if (item.abort_req)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            pins_next.data_line = shift_reg[1];
                            delay_next          = '0;
                            phase_next          = PH_SETUP;
                        end
                    end
                end
                else if (wait_reg >= cfg.limit)
                begin
                    // watchdog wins over abort, but abort keeps the flag clear
                    tflag_next = !item.abort_req;
                    done       = 1'b1;
                end
                else if (item.abort_req)
                begin
                    tflag_next = 1'b0;
                    done       = 1'b1;
                end
                else
                begin
                    wait_next = wait_reg + 1'b1;
                end
            end
            PH_DRY1:
            begin
                delay_next = delay_inc;
                if (delay_over)
                begin
                    pins_next.strobe_n = 1'b0;
                    delay_next         = '0;
                    phase_next         = PH_DRY2;
                end
            end
            PH_DRY2:
            begin
                delay_next = delay_inc;
                if (delay_over)
                begin
                    pins_next.strobe_n = 1'b1;
                    delay_next         = '0;
                    phase_next         = PH_DRY3;
                end
            end
            PH_DRY3:
            begin
                delay_next = delay_inc;
                if (delay_over)
                begin
                    shift_next   = shift_reg >> 1;
                    bit_cnt_next = bit_inc;
                    if (item.abort_req)
                    begin
                        done = 1'b1;
                    end
                    else if (last_bit)
                    begin
                        done = 1'b1;
                        ok   = 1'b1;
                    end
                    else
                    begin
                        pins_next.data_line = shift_reg[1];
                        delay_next          = '0;
                        phase_next          = PH_DRY1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                pins_next  = PINS_IDLE;
            end
        endcase

        if (done)
        begin
            phase_next = PH_IDLE;
            pins_next  = PINS_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            shift_reg   <= '0;
            bit_cnt_reg <= '0;
            delay_reg   <= '0;
            wait_reg    <= '0;
            tflag_reg   <= 1'b0;
            pins_reg    <= PINS_IDLE;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            shift_reg   <= shift_next;
            bit_cnt_reg <= bit_cnt_next;
            delay_reg   <= delay_next;
            wait_reg    <= wait_next;
            tflag_reg   <= tflag_next;
            pins_reg    <= pins_next;
        end
    end

    assign res.online_n  = pins_next.online_n;
    assign res.strobe_n  = pins_next.strobe_n;
    assign res.data_line = pins_next.data_line;
    assign res.busy_res  = (phase_next != PH_IDLE);
    assign res.done_res  = done;
    assign res.success   = done && ok;
    assign res.timed_out = tflag_next;

endmodule
